// ----- src/rsct_pkg.sv -----
package rsct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = IDX_W + 1;

    localparam int ADDR_W = 16;
    localparam int SEQ_W  = 32;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED         = 2'd0,
        STATUS_UNICAST_REPLAY   = 2'd1,
        STATUS_BROADCAST_REPLAY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_MISS,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic              inc;
        logic [IDX_W-1:0]  addr;
        logic [ADDR_W-1:0] src;
        logic [SEQ_W-1:0]  seq;
    } tbl_wr_t;

endpackage

// ----- src/rsct_table.sv -----
module rsct_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [rsct_pkg::IDX_W-1:0]  rd_addr,
    input  rsct_pkg::tbl_wr_t           wr,
    output logic [rsct_pkg::ADDR_W-1:0] rd_src,
    output logic [rsct_pkg::SEQ_W-1:0]  rd_seq,
    output logic [rsct_pkg::CNT_W-1:0]  used
);

    logic [rsct_pkg::ADDR_W-1:0] src_mem [rsct_pkg::TABLE_ENTRIES];
    logic [rsct_pkg::SEQ_W-1:0]  seq_mem [rsct_pkg::TABLE_ENTRIES];
    logic [rsct_pkg::ADDR_W-1:0] rd_src_reg;
    logic [rsct_pkg::SEQ_W-1:0]  rd_seq_reg;
    logic [rsct_pkg::CNT_W-1:0]  used_reg;
    logic [rsct_pkg::CNT_W-1:0]  used_next;

    // Slots fill in order and are never freed, so a slot is valid exactly
    // when its index is below the fill count.
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            src_mem[wr.addr] <= wr.src;
            seq_mem[wr.addr] <= wr.seq;
        end
        rd_src_reg <= src_mem[rd_addr];
        rd_seq_reg <= seq_mem[rd_addr];
    end

    always_comb begin
        used_next = used_reg;
        if (wr.we && wr.inc) begin
            used_next = used_reg + rsct_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

    assign rd_src = rd_src_reg;
    assign rd_seq = rd_seq_reg;
    assign used   = used_reg;

endmodule

// ----- src/replay_sequence_check_table.sv -----
// Per-source anti-replay check. A packet transaction on the s_ channel carries
// a source address, a destination address and a sequence number. For every
// packet exactly one result transaction leaves on the m_ channel with a status
// (accepted, unicast replay or broadcast replay), a first_seen flag and a
// not_stored flag for a new source that found the table full.
// The table is searched by one comparator, one entry per cycle, from a
// memory with a registered read port. An empty table is not scanned; else
// the scan runs over the filled slots up to and including the match.
// s_ready is high only while no packet is being checked, so one packet is
// in work at a time and a new packet waits until the last one has finished.
// The result sits in an output register; a new packet is accepted while it
// waits. If m_ready stays low, the next finished result is held inside until
// the output register frees, and no further packet is accepted meanwhile.
// The broadcast address is written with cfg_we and cfg_wdata; the user must
// do so only while the block is idle, and the block does not enforce it.
// Synchronous active-low reset empties the table, sets the broadcast
// address to all ones and drops m_valid.
module replay_sequence_check_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rsct_pkg::ADDR_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rsct_pkg::ADDR_W-1:0] s_source_address,
    input  logic [rsct_pkg::ADDR_W-1:0] s_destination_address,
    input  logic [rsct_pkg::SEQ_W-1:0]  s_sequence_number,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic                        m_first_seen,
    output logic                        m_not_stored
);

    rsct_pkg::state_t state_reg, state_next;

    logic [rsct_pkg::ADDR_W-1:0] bcast_reg;
    logic [rsct_pkg::ADDR_W-1:0] src_reg;
    logic [rsct_pkg::ADDR_W-1:0] dst_reg;
    logic [rsct_pkg::SEQ_W-1:0]  seq_reg;
    logic [rsct_pkg::IDX_W-1:0]  idx_reg, idx_next;

    rsct_pkg::status_t res_status_reg, res_status_next;
    logic              res_first_reg, res_first_next;
    logic              res_unstored_reg, res_unstored_next;

    logic              m_valid_reg, m_valid_next;
    rsct_pkg::status_t m_status_reg;
    logic              m_first_reg;
    logic              m_unstored_reg;
    logic              out_load;

    logic [rsct_pkg::IDX_W-1:0]  rd_addr;
    logic [rsct_pkg::ADDR_W-1:0] rd_src;
    logic [rsct_pkg::SEQ_W-1:0]  rd_seq;
    logic [rsct_pkg::CNT_W-1:0]  used;
    rsct_pkg::tbl_wr_t           tbl_wr;

    logic s_accept;
    logic last_entry;

    assign s_ready  = (state_reg == rsct_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign last_entry = ({1'b0, idx_reg} + rsct_pkg::CNT_W'(1)) == used;

    rsct_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .wr      (tbl_wr),
        .rd_src  (rd_src),
        .rd_seq  (rd_seq),
        .used    (used)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsct_pkg::ST_IDLE;
            bcast_reg   <= {rsct_pkg::ADDR_W{1'b1}};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                bcast_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg          <= idx_next;
        res_status_reg   <= res_status_next;
        res_first_reg    <= res_first_next;
        res_unstored_reg <= res_unstored_next;
        if (s_accept) begin
            src_reg <= s_source_address;
            dst_reg <= s_destination_address;
            seq_reg <= s_sequence_number;
        end
        if (out_load) begin
            m_status_reg   <= res_status_reg;
            m_first_reg    <= res_first_reg;
            m_unstored_reg <= res_unstored_reg;
        end
    end

    always_comb begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        res_status_next   = res_status_reg;
        res_first_next    = res_first_reg;
        res_unstored_next = res_unstored_reg;
        rd_addr           = idx_reg;
        out_load          = 1'b0;
        m_valid_next      = m_valid_reg && !m_ready;
        tbl_wr.we         = 1'b0;
        tbl_wr.inc        = 1'b0;
        tbl_wr.addr       = idx_reg;
        tbl_wr.src        = src_reg;
        tbl_wr.seq        = seq_reg;

        case (state_reg)
            rsct_pkg::ST_IDLE: begin
                idx_next = '0;
                rd_addr  = '0;
                if (s_accept) begin
                    state_next = (used == '0) ? rsct_pkg::ST_MISS : rsct_pkg::ST_SCAN;
                end
            end
            rsct_pkg::ST_SCAN: begin
                // The read data belongs to entry idx_reg; the next address is
                // issued in the same cycle so one entry is checked per cycle.
                if (rd_src == src_reg) begin
                    state_next = rsct_pkg::ST_CHECK;
                end else if (last_entry) begin
                    state_next = rsct_pkg::ST_MISS;
                end else begin
                    idx_next = idx_reg + rsct_pkg::IDX_W'(1);
                    rd_addr  = idx_next;
                end
            end
            rsct_pkg::ST_CHECK: begin
                res_first_next    = 1'b0;
                res_unstored_next = 1'b0;
                if (seq_reg > rd_seq) begin
                    res_status_next = rsct_pkg::STATUS_ACCEPTED;
                    tbl_wr.we       = 1'b1;
                end else if (dst_reg == bcast_reg) begin
                    res_status_next = rsct_pkg::STATUS_BROADCAST_REPLAY;
                end else begin
                    res_status_next = rsct_pkg::STATUS_UNICAST_REPLAY;
                end
                state_next = rsct_pkg::ST_DONE;
            end
            rsct_pkg::ST_MISS: begin
                res_status_next = rsct_pkg::STATUS_ACCEPTED;
                res_first_next  = 1'b1;
                if (used == rsct_pkg::CNT_W'(rsct_pkg::TABLE_ENTRIES)) begin
                    res_unstored_next = 1'b1;
                end else begin
                    res_unstored_next = 1'b0;
                    tbl_wr.we         = 1'b1;
                    tbl_wr.inc        = 1'b1;
                    tbl_wr.addr       = used[rsct_pkg::IDX_W-1:0];
                end
                state_next = rsct_pkg::ST_DONE;
            end
            rsct_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = rsct_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rsct_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_first_seen = m_first_reg;
    assign m_not_stored = m_unstored_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used <= rsct_pkg::CNT_W'(rsct_pkg::TABLE_ENTRIES))
        else $error("table fill count exceeds the number of slots");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr.we |-> (state_reg == rsct_pkg::ST_CHECK || state_reg == rsct_pkg::ST_MISS))
        else $error("table written outside a check or insert step");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == rsct_pkg::ST_DONE))
        else $error("result raised without a finished packet");

    a_unstored_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_first_seen || !m_not_stored))
        else $error("not_stored set for a known source");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status != 2'd3))
        else $error("undefined status code on result");
`endif

endmodule

// ----- verif/replay_sequence_check_table_test.sv -----
`timescale 1ns / 1ps

module replay_sequence_check_table_test;

    localparam int STALL_LIMIT = 4000;
    localparam int IDLE_PCT    = 27;

    typedef struct packed {
        rsct_pkg::status_t status;
        logic              first_seen;
        logic              not_stored;
    } verdict_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [rsct_pkg::ADDR_W-1:0] cfg_wdata = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [rsct_pkg::ADDR_W-1:0] s_source_address = '0;
    logic [rsct_pkg::ADDR_W-1:0] s_destination_address = '0;
    logic [rsct_pkg::SEQ_W-1:0]  s_sequence_number = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [1:0]                  m_status;
    logic                        m_first_seen;
    logic                        m_not_stored;

    // Shadow of the sequence table and the broadcast register.
    bit                          known_valid [rsct_pkg::TABLE_ENTRIES];
    logic [rsct_pkg::ADDR_W-1:0] known_src [rsct_pkg::TABLE_ENTRIES];
    logic [rsct_pkg::SEQ_W-1:0]  known_seq [rsct_pkg::TABLE_ENTRIES];
    int                          known_used = 0;
    logic [rsct_pkg::ADDR_W-1:0] bcast_addr = 16'hFFFF;

    verdict_t pending_verdicts [$];
    bit       idle_en = 1'b1;
    int       mismatches = 0;
    int       quiet_cycles = 0;

    replay_sequence_check_table uut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_we                (cfg_we),
        .cfg_wdata             (cfg_wdata),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_source_address      (s_source_address),
        .s_destination_address (s_destination_address),
        .s_sequence_number     (s_sequence_number),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_status              (m_status),
        .m_first_seen          (m_first_seen),
        .m_not_stored          (m_not_stored)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void predict_verdict(input logic [rsct_pkg::ADDR_W-1:0] src,
                                            input logic [rsct_pkg::ADDR_W-1:0] dst,
                                            input logic [rsct_pkg::SEQ_W-1:0] seq);
        verdict_t v;
        int slot;
        v.status = rsct_pkg::STATUS_ACCEPTED;
        v.first_seen = 1'b0;
        v.not_stored = 1'b0;
        slot = -1;
        for (int i = 0; i < rsct_pkg::TABLE_ENTRIES; i++) begin
            if (slot < 0 && known_valid[i] && known_src[i] == src) begin
                slot = i;
            end
        end
        if (slot < 0) begin
            v.first_seen = 1'b1;
            if (known_used < rsct_pkg::TABLE_ENTRIES) begin
                known_valid[known_used] = 1'b1;
                known_src[known_used] = src;
                known_seq[known_used] = seq;
                known_used++;
            end else begin
                v.not_stored = 1'b1;
            end
        end else if (seq <= known_seq[slot]) begin
            v.status = (dst == bcast_addr) ? rsct_pkg::STATUS_BROADCAST_REPLAY
                                           : rsct_pkg::STATUS_UNICAST_REPLAY;
        end else begin
            known_seq[slot] = seq;
        end
        pending_verdicts.push_back(v);
    endfunction

    // The valid line is left high after a transaction so that a following
    // packet without a gap needs no second assignment in the same step.
    task automatic send_packet(input logic [rsct_pkg::ADDR_W-1:0] src,
                               input logic [rsct_pkg::ADDR_W-1:0] dst,
                               input logic [rsct_pkg::SEQ_W-1:0] seq);
        if (idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_valid <= 1'b1;
        s_source_address <= src;
        s_destination_address <= dst;
        s_sequence_number <= seq;
        do @(posedge aclk); while (!s_ready);
        predict_verdict(src, dst, seq);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_broadcast(input logic [rsct_pkg::ADDR_W-1:0] addr);
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_wdata <= addr;
        @(posedge aclk);
        bcast_addr = addr;
        cfg_we <= 1'b0;
    endtask

    // Runs with the broadcast address still at its reset value.
    task automatic test_replay_rules();
        send_packet(16'h0000, 16'h1234, 32'h0000_0000);
        send_packet(16'h0000, 16'h1234, 32'h0000_0000);
        send_packet(16'h0000, 16'hFFFF, 32'h0000_0000);
        send_packet(16'h0000, 16'h0000, 32'h0000_0001);
        send_packet(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_packet(16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        send_packet(16'hFFFF, 16'hFFFF, 32'h0000_0000);
        send_packet(16'h0000, 16'h5555, 32'h8000_0000);
        send_packet(16'h0000, 16'hAAAA, 32'h7FFF_FFFF);
    endtask

    task automatic test_broadcast_register();
        write_broadcast(16'h0000);
        send_packet(16'h0000, 16'h0000, 32'h0000_0005);
        send_packet(16'h0000, 16'hFFFF, 32'h0000_0005);
    endtask

    task automatic test_table_fill();
        while (known_used < rsct_pkg::TABLE_ENTRIES) begin
            send_packet(16'h1000 + 16'(known_used), 16'($urandom), $urandom);
        end
    endtask

    // A new source on a full table is accepted but forgotten, so it stays new.
    task automatic test_table_full();
        send_packet(16'hABCD, 16'h0001, 32'h0000_0007);
        send_packet(16'hABCD, 16'h0001, 32'h0000_0007);
    endtask

    task automatic test_random_traffic(input int count,
                                       input logic [rsct_pkg::ADDR_W-1:0] addr,
                                       input bit with_idle);
        int pick;
        int slot;
        logic [rsct_pkg::SEQ_W-1:0] last;
        logic [rsct_pkg::SEQ_W-1:0] seq;
        logic [rsct_pkg::ADDR_W-1:0] src;
        logic [rsct_pkg::ADDR_W-1:0] dst;
        write_broadcast(addr);
        idle_en = with_idle;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            slot = $urandom_range(known_used - 1);
            src = known_src[slot];
            last = known_seq[slot];
            dst = $urandom_range(1) ? bcast_addr : 16'($urandom);
            if (pick < 60) begin
                seq = (last > 32'hFFFF_FC00) ? $urandom : last + $urandom_range(1, 1000);
            end else if (pick < 80) begin
                seq = last - $urandom_range(0, (last < 1000) ? last : 1000);
            end else if (pick < 90) begin
                seq = $urandom;
            end else begin
                src = 16'($urandom);
                seq = $urandom;
            end
            send_packet(src, dst, seq);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin : check_results
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result transaction: status %0d first %0b unstored %0b",
                             m_status, m_first_seen, m_not_stored);
                end
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_status !== want.status || m_first_seen !== want.first_seen ||
                    m_not_stored !== want.not_stored) begin
                    if (mismatches < 10) begin
                        $display({"result mismatch: expected status %0d first %0b ",
                                  "unstored %0b, got status %0d first %0b unstored %0b"},
                                 want.status, want.first_seen, want.not_stored,
                                 m_status, m_first_seen, m_not_stored);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("replay_sequence_check_table_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_replay_rules();
        test_broadcast_register();
        test_table_fill();
        test_table_full();
        test_random_traffic(220, 16'hFFFF, 1'b1);
        test_random_traffic(200, 16'($urandom), 1'b0);
        test_random_traffic(220, 16'h0000, 1'b1);
        test_random_traffic(210, 16'($urandom), 1'b1);
        wait_for_results();
        repeat (30) @(posedge aclk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("replay_sequence_check_table_test OK");
        end else begin
            $display("replay_sequence_check_table_test NOT OK");
        end
        $finish;
    end

endmodule
